>>> rtl/hsm_pkg.sv
// ----------------------------------------------------------------------------
// Slot map shared definitions
// Request opcodes, result status codes and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package hsm_pkg;

    // Request opcodes, carried on s_tuser.
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // Result status codes, carried on m_tuser.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_BAD_HANDLE = 2'd2;
    localparam logic [1:0] ST_BAD_POS    = 2'd3;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;     // take the request and launch the table reads
        logic run_first;   // first execution step
        logic run_second;  // second step of a remove (move of the last entry)
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic second_pass; // the request is a valid remove and needs a second step
        logic out_free;    // the result register can be loaded in this cycle
    } sts_t;

endpackage

>>> rtl/hsm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port, read data registered and held while the
// read enable is low.
// ----------------------------------------------------------------------------
module hsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/hsm_ctrl.sv
// ----------------------------------------------------------------------------
// Slot map controller
// Sequences each request through capture, a first step and, for a remove,
// a second step, and holds off when the result register is still occupied.
// ----------------------------------------------------------------------------
module hsm_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output hsm_pkg::cmd_t cmd,
    input  hsm_pkg::sts_t sts
);

    typedef enum logic [1:0] {
        IDLE,
        FIRST,
        SECOND
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            IDLE: begin
                if (s_tvalid && ready_reg) begin
                    cmd.capture = 1'b1;
                    state_next  = FIRST;
                end
            end
            FIRST: begin
                if (sts.second_pass) begin
                    cmd.run_first = 1'b1;
                    state_next    = SECOND;
                end else if (sts.out_free) begin
                    cmd.run_first = 1'b1;
                    state_next    = IDLE;
                end
            end
            SECOND: begin
                if (sts.out_free) begin
                    cmd.run_second = 1'b1;
                    state_next     = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    // State and the registered ready.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == IDLE);
        end
    end

    assign s_tready = ready_reg;

endmodule

>>> rtl/hsm_dp.sv
// ----------------------------------------------------------------------------
// Slot map datapath
// Holds the handle table, the dense store, the free list head, the live
// count and the result register, and carries out the steps the controller
// commands.
// ----------------------------------------------------------------------------
module hsm_dp #(
    parameter int MAX_ENTRIES  = 64,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [79:0]   s_tdata,
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [79:0]   m_tdata,
    output logic [1:0]    m_tuser,
    input  hsm_pkg::cmd_t cmd,
    output hsm_pkg::sts_t sts
);

    localparam int HW  = $clog2(MAX_ENTRIES);       // handle and position bits
    localparam int CW  = $clog2(MAX_ENTRIES + 1);   // count and link bits
    localparam int XW  = (CW > 7) ? CW : 7;         // width for range compares
    localparam int HTW = CW + 1;                    // alive mark and link
    localparam int DSW = HW + PAYLOAD_BITS;         // owner and payload

    // Control state.
    logic [CW-1:0] count_reg, count_next;
    logic [HW-1:0] head_reg, head_next;
    logic          empty_reg, empty_next;
    logic [CW-1:0] hw_reg, hw_next;    // handles at or above this were never used

    // Request fields.
    logic [1:0]  opcode;
    logic [63:0] pay_in;
    logic [5:0]  hnd_in;
    logic [5:0]  pos_in;
    logic [XW-1:0] hnd_x, pos_x, max_x, count_x;

    assign opcode  = s_tuser;
    assign pay_in  = s_tdata[63:0];
    assign hnd_in  = s_tdata[69:64];
    assign pos_in  = s_tdata[75:70];
    assign hnd_x   = XW'(hnd_in);
    assign pos_x   = XW'(pos_in);
    assign max_x   = XW'(MAX_ENTRIES);
    assign count_x = XW'(count_reg);

    // Captured request.
    logic [1:0]              op_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [HW-1:0]           h_reg;
    logic                    hbad_reg;
    logic                    pbad_reg;
    logic                    fresh_reg;
    logic [HW-1:0]           hole_reg, hole_next;

    // Result register.
    logic        m_valid_reg;
    logic [1:0]  m_status_reg;
    logic [5:0]  m_hnd_reg;
    logic [63:0] m_pay_reg;
    logic [6:0]  m_cnt_reg;

    // Memory ports.
    logic           ht_we, ht_re;
    logic [HW-1:0]  ht_waddr, ht_raddr;
    logic [HTW-1:0] ht_wdata, ht_rdata;
    logic           ds_we, ds_re;
    logic [HW-1:0]  ds_waddr, ds_raddr;
    logic [DSW-1:0] ds_wdata, ds_rdata;

    hsm_ram #(.WIDTH(HTW), .DEPTH(MAX_ENTRIES)) u_handle_ram (
        .aclk  (aclk),
        .we    (ht_we),
        .waddr (ht_waddr),
        .wdata (ht_wdata),
        .re    (ht_re),
        .raddr (ht_raddr),
        .rdata (ht_rdata)
    );

    hsm_ram #(.WIDTH(DSW), .DEPTH(MAX_ENTRIES)) u_dense_ram (
        .aclk  (aclk),
        .we    (ds_we),
        .waddr (ds_waddr),
        .wdata (ds_wdata),
        .re    (ds_re),
        .raddr (ds_raddr),
        .rdata (ds_rdata)
    );

    // Handle table entry as seen in the first step. An entry that was never
    // touched is treated as dead and linked to the next handle, whatever the RAM holds.
    logic          alive;
    logic [CW-1:0] link;
    logic          full;
    logic          rm_ok;
    logic [HW-1:0] ds_own;
    logic [PAYLOAD_BITS-1:0] ds_pay;

    assign alive  = !fresh_reg && ht_rdata[CW];
    assign link   = fresh_reg ? (CW'(h_reg) + CW'(1)) : ht_rdata[CW-1:0];
    assign full   = empty_reg || (count_reg >= CW'(MAX_ENTRIES));
    assign rm_ok  = (op_reg == hsm_pkg::OP_REMOVE) && !hbad_reg && alive
                    && (count_reg != '0);
    assign ds_own = ds_rdata[DSW-1:PAYLOAD_BITS];
    assign ds_pay = ds_rdata[PAYLOAD_BITS-1:0];

    assign sts.second_pass = rm_ok;
    assign sts.out_free    = !m_valid_reg || m_tready;

    // Handle table read address at capture: free head for add, else the handle.
    assign ht_raddr = (opcode == hsm_pkg::OP_ADD) ? head_reg : HW'(hnd_x);
    assign ht_re    = cmd.capture;

    // Step logic: memory writes, state updates and the result.
    logic                    out_load;
    logic [1:0]              out_status;
    logic [HW-1:0]           out_hnd;
    logic [PAYLOAD_BITS-1:0] out_pay;

    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        empty_next = empty_reg;
        hw_next    = hw_reg;
        hole_next  = hole_reg;
        out_load   = 1'b0;
        out_status = hsm_pkg::ST_OK;
        out_hnd    = '0;
        out_pay    = '0;
        ht_we      = 1'b0;
        ht_waddr   = h_reg;
        ht_wdata   = '0;
        ds_we      = 1'b0;
        ds_waddr   = HW'(count_reg);
        ds_wdata   = {h_reg, pay_reg};
        ds_re      = cmd.capture;
        ds_raddr   = HW'(pos_x);

        if (cmd.run_first) begin
            case (op_reg)
                hsm_pkg::OP_ADD: begin
                    out_load = 1'b1;
                    if (full) begin
                        out_status = hsm_pkg::ST_FULL;
                    end else begin
                        // Pop the free head and append the payload.
                        ht_we      = 1'b1;
                        ht_wdata   = {1'b1, count_reg};
                        ds_we      = 1'b1;
                        out_hnd    = h_reg;
                        count_next = count_reg + CW'(1);
                        if (link >= CW'(MAX_ENTRIES)) begin
                            empty_next = 1'b1;
                        end else begin
                            head_next = HW'(link);
                        end
                        if (fresh_reg) begin
                            hw_next = hw_reg + CW'(1);
                        end
                    end
                end
                hsm_pkg::OP_REMOVE: begin
                    if (rm_ok) begin
                        // Kill the handle, push it on the free list and fetch
                        // the last dense entry for the move.
                        ht_we      = 1'b1;
                        ht_wdata   = {1'b0, empty_reg ? CW'(MAX_ENTRIES) : CW'(head_reg)};
                        head_next  = h_reg;
                        empty_next = 1'b0;
                        count_next = count_reg - CW'(1);
                        ds_re      = 1'b1;
                        ds_raddr   = HW'(count_reg - CW'(1));
                        hole_next  = HW'(link);
                    end else begin
                        out_load   = 1'b1;
                        out_status = hsm_pkg::ST_BAD_HANDLE;
                    end
                end
                hsm_pkg::OP_READ: begin
                    out_load = 1'b1;
                    if (pbad_reg) begin
                        out_status = hsm_pkg::ST_BAD_POS;
                    end else begin
                        out_hnd = ds_own;
                        out_pay = ds_pay;
                    end
                end
                default: begin
                    out_load = 1'b1;
                end
            endcase
        end

        // Second step of a remove: fill the hole and repoint the mover, unless
        // the mover is the removed handle itself.
        if (cmd.run_second) begin
            ds_we    = 1'b1;
            ds_waddr = hole_reg;
            ds_wdata = ds_rdata;
            if (ds_own != h_reg) begin
                ht_we    = 1'b1;
                ht_waddr = ds_own;
                ht_wdata = {1'b1, CW'(hole_reg)};
            end
            out_load = 1'b1;
        end
    end

    // Control state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            head_reg  <= '0;
            empty_reg <= 1'b0;
            hw_reg    <= '0;
        end else begin
            count_reg <= count_next;
            head_reg  <= head_next;
            empty_reg <= empty_next;
            hw_reg    <= hw_next;
        end
    end

    // Request capture and remove bookkeeping.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= opcode;
            pay_reg   <= pay_in[PAYLOAD_BITS-1:0];
            h_reg     <= ht_raddr;
            hbad_reg  <= (hnd_x >= max_x);
            pbad_reg  <= (pos_x >= count_x) || (pos_x >= max_x);
            fresh_reg <= (CW'(ht_raddr) >= hw_reg);
        end
        hole_reg <= hole_next;
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_status_reg <= out_status;
            m_hnd_reg    <= 6'(out_hnd);
            m_pay_reg    <= 64'(out_pay);
            m_cnt_reg    <= 7'(count_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {3'b000, m_cnt_reg, m_pay_reg, m_hnd_reg};

endmodule

>>> rtl/handle_slot_map.sv
// ----------------------------------------------------------------------------
// Slot map with stable handles
// Adds, removes and reads entries of a densely packed payload store through
// handles that stay valid while their entry moves.
// ----------------------------------------------------------------------------
// An add, a read and the undefined opcode pass through capture and a first
// step before their result is loaded, and a remove adds a second step; a
// new request is accepted only once the last one has finished its steps.
// The steps follow from the registered reads of the two RAMs: every request
// first reads the handle table and the dense store, and a remove then needs a
// second, dependent read of the last dense entry before it can fill the hole.
// A finished result sits in an output register, so the next request is
// accepted while it waits; the block stalls only when a second result is
// ready before the first has been taken. Handles that were never handed out
// are tracked by a high-water mark, so the handle table needs no clearing
// pass after reset, and requests are accepted from the cycle after release.
// ----------------------------------------------------------------------------
module handle_slot_map #(
    parameter int MAX_ENTRIES  = 64,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // payload_in[63:0], handle_in[69:64],
                                   // dense_position[75:70], zeros above
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // handle_out[5:0], payload_out[69:6],
                                   // live_count[76:70], zeros above
    output logic [1:0]  m_tuser    // status[1:0]
);

    hsm_pkg::cmd_t cmd;
    hsm_pkg::sts_t sts;

    // Request sequencing.
    hsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Tables, state and result register.
    hsm_dp #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

    // A request is worked on alone: ready drops right after an accept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in progress");

    // The free list runs dry only when every handle is live.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == hsm_pkg::ST_FULL))
            |-> (m_tdata[76:70] == 7'(MAX_ENTRIES)))
        else $error("full reported with free handles left");

    // Rejected requests return no handle and no payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && ((m_tuser == hsm_pkg::ST_BAD_HANDLE)
                      || (m_tuser == hsm_pkg::ST_BAD_POS)))
            |-> (m_tdata[69:0] == '0))
        else $error("error result carries handle or payload data");

endmodule

>>> tb/handle_slot_map_tb.sv
// ----------------------------------------------------------------------------
// Slot map testbench
// Sends add, remove, read and undefined requests to the slot map. A local
// copy of the handle table, free list and dense store predicts every result,
// and each returned result is compared field by field with the oldest
// prediction. Directed cases come first, then a long output stall, then
// random traffic in phases that fill, drain and churn the map.
// ----------------------------------------------------------------------------
module handle_slot_map_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_HANDLES  = 64;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 150;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] payload;
        logic [5:0]  handle;
        logic [5:0]  position;
    } slot_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  handle;
        logic [63:0] payload;
        logic [6:0]  live_count;
    } slot_rsp_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;

    // Traffic shaping controls, changed by the test tasks.
    logic sender_idle;
    logic receiver_idle;
    logic receiver_hold;

    int mismatch_count = 0;

    // Predicted results in request order.
    slot_rsp_t expected_results[$];

    // Local copy of the slot map state.
    logic        map_alive   [NUM_HANDLES];
    logic [6:0]  map_link    [NUM_HANDLES];
    logic [63:0] map_payload [NUM_HANDLES];
    logic [5:0]  map_owner   [NUM_HANDLES];
    logic [6:0]  map_free_head;
    logic        map_free_empty;
    logic [6:0]  map_count;

    handle_slot_map #(
        .MAX_ENTRIES (NUM_HANDLES),
        .PAYLOAD_BITS(64)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #2 aclk = ~aclk;

    // The free list starts as the chain 0, 1, 2, ... ending at NUM_HANDLES.
    task automatic reset_slot_model();
        for (int i = 0; i < NUM_HANDLES; i++) begin
            map_alive[i]   = 1'b0;
            map_link[i]    = 7'(i + 1);
            map_payload[i] = '0;
            map_owner[i]   = '0;
        end
        map_free_head  = '0;
        map_free_empty = 1'b0;
        map_count      = '0;
    endtask

    // Applies one request to the local state and returns the result it gives.
    function automatic slot_rsp_t slot_map_step(input slot_req_t rq);
        slot_rsp_t  rsp;
        logic [5:0] h;
        logic [6:0] hole;
        logic [5:0] last;
        logic [5:0] mover;
        rsp        = '0;
        rsp.status = hsm_pkg::ST_OK;
        case (rq.opcode)
            hsm_pkg::OP_ADD: begin
                if (map_free_empty || map_free_head >= NUM_HANDLES ||
                    map_count >= NUM_HANDLES) begin
                    rsp.status = hsm_pkg::ST_FULL;
                end else begin
                    h = map_free_head[5:0];
                    if (map_link[h] >= NUM_HANDLES) begin
                        map_free_empty = 1'b1;
                    end else begin
                        map_free_head = map_link[h];
                    end
                    map_alive[h]                = 1'b1;
                    map_link[h]                 = map_count;
                    map_payload[map_count[5:0]] = rq.payload;
                    map_owner[map_count[5:0]]   = h;
                    map_count                   = map_count + 7'd1;
                    rsp.handle                  = h;
                end
            end
            hsm_pkg::OP_REMOVE: begin
                h = rq.handle;
                if (!map_alive[h] || map_count == 0) begin
                    rsp.status = hsm_pkg::ST_BAD_HANDLE;
                end else begin
                    hole = map_link[h];
                    last = 6'(map_count - 7'd1);
                    // The last dense entry fills the hole and its handle follows it.
                    if (hole < NUM_HANDLES) begin
                        map_payload[hole[5:0]] = map_payload[last];
                        map_owner[hole[5:0]]   = map_owner[last];
                        mover                  = map_owner[hole[5:0]];
                        map_link[mover]        = hole;
                    end
                    map_count      = map_count - 7'd1;
                    map_alive[h]   = 1'b0;
                    map_link[h]    = map_free_empty ? 7'(NUM_HANDLES) : map_free_head;
                    map_free_head  = {1'b0, h};
                    map_free_empty = 1'b0;
                end
            end
            hsm_pkg::OP_READ: begin
                if ({1'b0, rq.position} >= map_count) begin
                    rsp.status = hsm_pkg::ST_BAD_POS;
                end else begin
                    rsp.payload = map_payload[rq.position];
                    rsp.handle  = map_owner[rq.position];
                end
            end
            default: begin
                // The undefined opcode leaves the map as it is.
            end
        endcase
        rsp.live_count = map_count;
        return rsp;
    endfunction

    function automatic slot_req_t make_request(input logic [1:0] op, input logic [63:0] payload,
                                               input logic [5:0] handle,
                                               input logic [5:0] position);
        slot_req_t rq;
        rq.opcode   = op;
        rq.payload  = payload;
        rq.handle   = handle;
        rq.position = position;
        return rq;
    endfunction

    // A live handle, taken from the owner of a random dense position, or a random handle when the map is empty.
    function automatic logic [5:0] pick_live_handle();
        if (map_count == 0) begin
            return 6'($urandom);
        end
        return map_owner[$urandom_range(0, int'(map_count) - 1)];
    endfunction

    // Mostly well-formed requests; a few carry random handles or positions.
    function automatic slot_req_t random_request(input int add_pct, input int remove_pct);
        slot_req_t rq;
        int        pick;
        rq   = make_request(hsm_pkg::OP_NOP, {$urandom, $urandom},
                            6'($urandom), 6'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < add_pct) begin
            rq.opcode = hsm_pkg::OP_ADD;
        end else if (pick < add_pct + remove_pct) begin
            rq.opcode = hsm_pkg::OP_REMOVE;
            if ($urandom_range(0, 9) != 0) begin
                rq.handle = pick_live_handle();
            end
        end else if (pick < 98) begin
            rq.opcode = hsm_pkg::OP_READ;
            if ($urandom_range(0, 9) != 0 && map_count != 0) begin
                rq.position = 6'($urandom_range(0, int'(map_count) - 1));
            end
        end
        return rq;
    endfunction

    // Offers one request after a random gap and predicts its result on acceptance.
    task automatic send_request(input slot_req_t rq);
        int gap;
        gap = sender_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.opcode;
        s_tdata  <= {4'b0, rq.position, rq.handle, rq.payload};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(slot_map_step(rq));
    endtask

    function automatic void report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("Mismatch at %0t ns: %s", $realtime, msg);
        end
    endfunction

    // Result consumer: random stall before each result, plus an optional long hold.
    initial begin : receiver
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (receiver_hold) begin
                receiver_hold = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                stall = receiver_idle ? $urandom_range(0, 7) : 0;
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Compare every accepted result with the oldest prediction.
    always @(posedge aclk) begin : check_results
        slot_rsp_t got;
        slot_rsp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status     = m_tuser;
            got.handle     = m_tdata[5:0];
            got.payload    = m_tdata[69:6];
            got.live_count = m_tdata[76:70];
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with none expected: status %0d handle %0d",
                                          got.status, got.handle));
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status expected %0d, got %0d",
                                              want.status, got.status));
                if (got.handle !== want.handle)
                    report_mismatch($sformatf("handle expected %0d, got %0d",
                                              want.handle, got.handle));
                if (got.payload !== want.payload)
                    report_mismatch($sformatf("payload expected %h, got %h",
                                              want.payload, got.payload));
                if (got.live_count !== want.live_count)
                    report_mismatch($sformatf("live count expected %0d, got %0d",
                                              want.live_count, got.live_count));
            end
        end
    end

    // Extreme payloads, every opcode, moves on remove, dead handles and bad positions.
    task automatic test_directed_cases();
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        send_request(make_request(hsm_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 6'd0));
        send_request(make_request(hsm_pkg::OP_ADD, 64'h0, 6'd63, 6'd63));
        send_request(make_request(hsm_pkg::OP_ADD, 64'h5555_5555_5555_5555, 6'd0, 6'd0));
        send_request(make_request(hsm_pkg::OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 6'd0, 6'd0));
        for (int p = 0; p < 4; p++) begin
            send_request(make_request(hsm_pkg::OP_READ, 64'h0, 6'd0, 6'(p)));
        end
        send_request(make_request(hsm_pkg::OP_READ, 64'h0, 6'd0, 6'd4));
        send_request(make_request(hsm_pkg::OP_READ, 64'h0, 6'd0, 6'd63));
        // Removing a middle entry moves the last entry into its place.
        send_request(make_request(hsm_pkg::OP_REMOVE, 64'h0, 6'd1, 6'd0));
        send_request(make_request(hsm_pkg::OP_READ, 64'h0, 6'd0, 6'd1));
        send_request(make_request(hsm_pkg::OP_REMOVE, 64'h0, 6'd1, 6'd0));
        send_request(make_request(hsm_pkg::OP_REMOVE, 64'h0, 6'd63, 6'd0));
        send_request(make_request(hsm_pkg::OP_NOP, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 6'd63));
        // Removing the last dense entry needs no move.
        send_request(make_request(hsm_pkg::OP_REMOVE, 64'h0, 6'd2, 6'd0));
        send_request(make_request(hsm_pkg::OP_ADD, 64'h0123_4567_89AB_CDEF, 6'd0, 6'd0));
        send_request(make_request(hsm_pkg::OP_REMOVE, 64'h0, 6'd0, 6'd0));
        send_request(make_request(hsm_pkg::OP_REMOVE, 64'h0, 6'd3, 6'd0));
        send_request(make_request(hsm_pkg::OP_REMOVE, 64'h0, 6'd2, 6'd0));
        send_request(make_request(hsm_pkg::OP_REMOVE, 64'h0, 6'd0, 6'd0));
        send_request(make_request(hsm_pkg::OP_READ, 64'h0, 6'd0, 6'd0));
    endtask

    // The consumer stops for a long time while requests keep coming.
    task automatic test_output_backpressure();
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        receiver_hold = 1'b1;
        for (int i = 0; i < 24; i++) begin
            send_request(random_request(60, 20));
        end
    endtask

    // Phases that fill the map to full, drain it to empty and churn it.
    task automatic test_random_traffic(input int num_items);
        int add_pct;
        int remove_pct;
        for (int i = 0; i < num_items; i++) begin
            if (i % PHASE_ITEMS == 0) begin
                case ((i / PHASE_ITEMS) % 4)
                    0: begin add_pct = 70; remove_pct = 15; end
                    1: begin add_pct = 15; remove_pct = 70; end
                    2: begin add_pct = 40; remove_pct = 40; end
                    default: begin add_pct = 80; remove_pct = 10; end
                endcase
                sender_idle   = ($urandom_range(0, 3) != 0);
                receiver_idle = ($urandom_range(0, 3) != 0);
            end
            send_request(random_request(add_pct, remove_pct));
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = hsm_pkg::OP_NOP;
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        receiver_hold = 1'b0;
        reset_slot_model();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_output_backpressure();
        test_random_traffic(1900);
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Overall time limit.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
